// File: design/laser_line_column_triangulation_macros.svh
// assertion macros for the laser line column triangulation block
`ifndef LASER_LINE_COLUMN_TRIANGULATION_MACROS_SVH
`define LASER_LINE_COLUMN_TRIANGULATION_MACROS_SVH

// condition holds in the same cycle
`define LLT_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// condition holds in the next cycle
`define LLT_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/lltri_pkg.sv
// shared constants and types for the laser line column triangulation block
`default_nettype none

package lltri_pkg;

    localparam int MAX_COLUMNS = 2048;
    localparam int COL_AW = $clog2(MAX_COLUMNS);
    localparam int COLX_W = 14;
    localparam logic [7:0] THRESHOLD = 8'd45;
    localparam int EPOCH_W = 8;

    localparam int DIV_NUM_W = 62;
    localparam int DIV_DEN_W = 42;
    localparam int DIV_CNT_W = $clog2(DIV_NUM_W);

    typedef logic signed [DIV_NUM_W:0] div_num_t;
    typedef logic signed [DIV_DEN_W:0] div_den_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

`default_nettype wire

// File: design/lltri_div.sv
// sequential signed divider, one quotient bit per cycle, truncating toward zero
`default_nettype none

module lltri_div (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  lltri_pkg::div_num_t dividend,
    input  lltri_pkg::div_den_t divisor,
    output lltri_pkg::div_stat_t stat,
    output lltri_pkg::div_num_t quotient
);

    logic [lltri_pkg::DIV_NUM_W-1:0] work_reg;
    logic [lltri_pkg::DIV_DEN_W-1:0] den_reg;
    logic [lltri_pkg::DIV_DEN_W-1:0] rem_reg;
    logic                            neg_reg;
    logic [lltri_pkg::DIV_CNT_W-1:0] cnt_reg;
    logic                            busy_reg;
    logic                            done_reg;

    logic [lltri_pkg::DIV_NUM_W:0]   num_abs;
    logic [lltri_pkg::DIV_DEN_W:0]   den_abs;
    logic [lltri_pkg::DIV_DEN_W:0]   rem_shift;
    logic [lltri_pkg::DIV_DEN_W:0]   rem_diff;
    logic                            fits;

    assign num_abs = dividend[lltri_pkg::DIV_NUM_W] ? (~dividend + 1'b1) : dividend;
    assign den_abs = divisor[lltri_pkg::DIV_DEN_W] ? (~divisor + 1'b1) : divisor;
    assign rem_shift = {rem_reg, work_reg[lltri_pkg::DIV_NUM_W-1]};
    assign fits = rem_shift >= {1'b0, den_reg};
    assign rem_diff = rem_shift - {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == lltri_pkg::DIV_CNT_W'(lltri_pkg::DIV_NUM_W - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            work_reg <= num_abs[lltri_pkg::DIV_NUM_W-1:0];
            den_reg  <= den_abs[lltri_pkg::DIV_DEN_W-1:0];
            rem_reg  <= '0;
            neg_reg  <= dividend[lltri_pkg::DIV_NUM_W] ^ divisor[lltri_pkg::DIV_DEN_W];
        end
        else if (busy_reg)
        begin
            rem_reg  <= fits ? rem_diff[lltri_pkg::DIV_DEN_W-1:0]
                             : rem_shift[lltri_pkg::DIV_DEN_W-1:0];
            work_reg <= {work_reg[lltri_pkg::DIV_NUM_W-2:0], fits};
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient = neg_reg ? lltri_pkg::div_num_t'(~{1'b0, work_reg} + 1'b1)
                              : lltri_pkg::div_num_t'({1'b0, work_reg});

endmodule

`default_nettype wire

// File: design/laser_line_column_triangulation.sv
// laser line column triangulation: first lit pixel per column to lateral offset and depth
// a pixel that gives no result only passes through accept and tag memory lookup
// a lit pixel then goes through four divisions in the shared divider (three on a zero depth
// denominator), a 17 step square root and further datapath steps, plus any output stall
// the column tag memory is swept over all 2048 columns after reset and on every 255th frame
// start; pixels are held off during the sweep, configuration writes are always taken
`default_nettype none

`include "laser_line_column_triangulation_macros.svh"

module laser_line_column_triangulation (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [7:0]         gray_level,
    input  logic [10:0]        column,
    input  logic [10:0]        row,
    input  logic               frame_start,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [10:0]        hit_column,
    output logic [10:0]        hit_row,
    output logic signed [23:0] lateral_offset,
    output logic signed [23:0] depth,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [15:0]        cfg_data
);

    localparam logic [2:0] CFG_FOCAL_U  = 3'd0;
    localparam logic [2:0] CFG_FOCAL_V  = 3'd1;
    localparam logic [2:0] CFG_CENTER_U = 3'd2;
    localparam logic [2:0] CFG_CENTER_V = 3'd3;
    localparam logic [2:0] CFG_K1       = 3'd4;
    localparam logic [2:0] CFG_K2       = 3'd5;
    localparam logic [2:0] CFG_HEIGHT   = 3'd6;
    localparam logic [2:0] CFG_BASELINE = 3'd7;

    localparam logic [4:0] ST_IDLE  = 5'd0;
    localparam logic [4:0] ST_CLEAR = 5'd1;
    localparam logic [4:0] ST_RD    = 5'd2;
    localparam logic [4:0] ST_LOOK  = 5'd3;
    localparam logic [4:0] ST_XD    = 5'd4;
    localparam logic [4:0] ST_XDW   = 5'd5;
    localparam logic [4:0] ST_YD    = 5'd6;
    localparam logic [4:0] ST_YDW   = 5'd7;
    localparam logic [4:0] ST_SQA   = 5'd8;
    localparam logic [4:0] ST_R2    = 5'd9;
    localparam logic [4:0] ST_R4    = 5'd10;
    localparam logic [4:0] ST_FT    = 5'd11;
    localparam logic [4:0] ST_F     = 5'd12;
    localparam logic [4:0] ST_E     = 5'd13;
    localparam logic [4:0] ST_N1    = 5'd14;
    localparam logic [4:0] ST_N2    = 5'd15;
    localparam logic [4:0] ST_N3    = 5'd16;
    localparam logic [4:0] ST_SQRT  = 5'd17;
    localparam logic [4:0] ST_ZD    = 5'd18;
    localparam logic [4:0] ST_ZDW   = 5'd19;
    localparam logic [4:0] ST_Y1    = 5'd20;
    localparam logic [4:0] ST_YD2   = 5'd21;
    localparam logic [4:0] ST_YDW2  = 5'd22;
    localparam logic [4:0] ST_DONE  = 5'd23;

    function automatic logic signed [23:0] sat24(input logic signed [63:0] v);
        logic signed [23:0] r;
        if (v > 64'sd8388607)
            r = 24'sh7FFFFF;
        else if (v < -64'sd8388608)
            r = 24'sh800000;
        else
            r = v[23:0];
        return r;
    endfunction

    // configuration
    logic [15:0]        fu_reg;
    logic [15:0]        fv_reg;
    logic [11:0]        cu_reg;
    logic [11:0]        cv_reg;
    logic signed [15:0] k1_reg;
    logic signed [15:0] k2_reg;
    logic [15:0]        h_reg;
    logic [15:0]        b_reg;

    // control
    logic [4:0]                      state_reg;
    logic [4:0]                      state_next;
    logic [lltri_pkg::EPOCH_W-1:0]   epoch_reg;
    logic [lltri_pkg::COL_AW-1:0]    clr_cnt_reg;
    logic                            pending_reg;
    logic                            out_valid_reg;

    // tag memory
    logic [lltri_pkg::EPOCH_W-1:0]   tag_mem [lltri_pkg::MAX_COLUMNS];
    logic [lltri_pkg::EPOCH_W-1:0]   tag_rdata_reg;
    logic [lltri_pkg::COL_AW-1:0]    tag_raddr;
    logic [lltri_pkg::COL_AW-1:0]    tag_waddr;
    logic [lltri_pkg::EPOCH_W-1:0]   tag_wdata;
    logic                            tag_we;

    // item and datapath
    logic [10:0]        col_reg;
    logic [10:0]        row_reg;
    logic               hit_ok_reg;
    logic signed [28:0] xd_reg;
    logic signed [28:0] yd_reg;
    logic [56:0]        xsq_reg;
    logic [56:0]        ysq_reg;
    logic [30:0]        r2_reg;
    logic [45:0]        r4_reg;
    logic signed [47:0] t1_reg;
    logic signed [62:0] t2_reg;
    logic signed [21:0] f_reg;
    logic signed [26:0] e_reg;
    logic [31:0]        fvh_reg;
    logic [31:0]        fvb_reg;
    logic signed [43:0] eb_reg;
    logic signed [43:0] he_reg;
    logic [31:0]        hh_reg;
    logic [31:0]        bb_reg;
    logic signed [45:0] num_reg;
    logic signed [45:0] den_reg;
    logic signed [62:0] nb_reg;
    logic signed [34:0] duf_reg;
    logic signed [52:0] dfh_reg;
    logic [33:0]        sq_x_reg;
    logic [33:0]        sq_res_reg;
    logic [33:0]        sq_bit_reg;
    logic signed [23:0] z_reg;
    logic signed [23:0] y_reg;

    logic [10:0]        hit_column_reg;
    logic [10:0]        hit_row_reg;
    logic signed [23:0] lateral_offset_reg;
    logic signed [23:0] depth_reg;

    logic                          in_accept;
    logic                          clear_last;
    logic                          epoch_full;
    logic                          fresh_hit;
    logic                          out_load;
    logic [lltri_pkg::COLX_W-1:0]  col_ext_in;
    logic [lltri_pkg::COLX_W-1:0]  col_ext_reg;
    logic [15:0]                   fu_eff;
    logic [15:0]                   fv_eff;
    logic signed [12:0]            du;
    logic signed [12:0]            dv;
    logic signed [12:0]            ndv;

    logic signed [57:0] xsq_full;
    logic signed [57:0] ysq_full;
    logic [57:0]        r2_sum;
    logic [61:0]        r4_full;
    logic signed [47:0] t1_full;
    logic signed [62:0] t2_full;
    logic signed [63:0] f_sum;
    logic signed [49:0] f_sh;
    logic signed [34:0] e_full;
    logic signed [43:0] eb_full;
    logic signed [43:0] he_full;
    logic signed [62:0] nb_full;
    logic signed [34:0] duf_full;
    logic signed [52:0] dfh_full;
    logic [33:0]        sq_sum;
    logic signed [63:0] z_full;

    logic                  div_start;
    lltri_pkg::div_num_t   div_num;
    lltri_pkg::div_den_t   div_den;
    lltri_pkg::div_stat_t  div_stat;
    lltri_pkg::div_num_t   div_quo;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    assign col_ext_in  = lltri_pkg::COLX_W'(column);
    assign col_ext_reg = lltri_pkg::COLX_W'(col_reg);
    assign epoch_full  = (epoch_reg == '1);
    assign clear_last  = (clr_cnt_reg == lltri_pkg::COL_AW'(lltri_pkg::MAX_COLUMNS - 1));
    assign fresh_hit   = hit_ok_reg && (tag_rdata_reg != epoch_reg);
    assign out_load    = (state_reg == ST_DONE) && (!out_valid_reg || !out_stall);

    assign fu_eff = (fu_reg == 16'd0) ? 16'd1 : fu_reg;
    assign fv_eff = (fv_reg == 16'd0) ? 16'd1 : fv_reg;
    assign du  = $signed({2'b00, col_reg}) - $signed({1'b0, cu_reg});
    assign dv  = $signed({2'b00, row_reg}) - $signed({1'b0, cv_reg});
    assign ndv = $signed({1'b0, cv_reg}) - $signed({2'b00, row_reg});

    assign xsq_full = xd_reg * xd_reg;
    assign ysq_full = yd_reg * yd_reg;
    assign r2_sum   = {1'b0, xsq_reg} + {1'b0, ysq_reg};
    assign r4_full  = r2_reg * r2_reg;
    assign t1_full  = k1_reg * $signed({1'b0, r2_reg});
    assign t2_full  = k2_reg * $signed({1'b0, r4_reg});
    assign f_sum    = 64'sh40000000 + 64'(t1_reg) + 64'(t2_reg);
    assign f_sh     = $signed(f_sum[63:14]);
    assign e_full   = ndv * f_reg;
    assign eb_full  = e_reg * $signed({1'b0, b_reg});
    assign he_full  = e_reg * $signed({1'b0, h_reg});
    assign nb_full  = num_reg * $signed({1'b0, b_reg});
    assign duf_full = du * f_reg;
    assign dfh_full = duf_reg * $signed({1'b0, sq_res_reg[16:0]});
    assign sq_sum   = sq_res_reg + sq_bit_reg;
    assign z_full   = $signed(64'({h_reg, 4'h0})) - 64'(div_quo);

    // tag memory ports
    assign tag_raddr = (state_reg == ST_IDLE) ? col_ext_in[lltri_pkg::COL_AW-1:0]
                                              : col_ext_reg[lltri_pkg::COL_AW-1:0];
    assign tag_we    = (state_reg == ST_CLEAR) || ((state_reg == ST_LOOK) && fresh_hit);
    assign tag_waddr = (state_reg == ST_CLEAR) ? clr_cnt_reg
                                               : col_ext_reg[lltri_pkg::COL_AW-1:0];
    assign tag_wdata = (state_reg == ST_CLEAR) ? '0 : epoch_reg;

    always_ff @(posedge clk)
    begin
        if (tag_we)
            tag_mem[tag_waddr] <= tag_wdata;
        tag_rdata_reg <= tag_mem[tag_raddr];
    end

    // divider operands
    always_comb
    begin
        div_start = 1'b0;
        div_num   = '0;
        div_den   = '0;
        case (state_reg)
            ST_XD:
            begin
                div_start = 1'b1;
                div_num   = lltri_pkg::div_num_t'($signed({du, 16'h0000}));
                div_den   = lltri_pkg::div_den_t'({1'b0, fu_eff});
            end
            ST_YD:
            begin
                div_start = 1'b1;
                div_num   = lltri_pkg::div_num_t'($signed({dv, 16'h0000}));
                div_den   = lltri_pkg::div_den_t'({1'b0, fv_eff});
            end
            ST_ZD:
            begin
                div_start = (den_reg != '0);
                div_num   = nb_reg;
                div_den   = lltri_pkg::div_den_t'(den_reg);
            end
            ST_YD2:
            begin
                div_start = 1'b1;
                div_num   = lltri_pkg::div_num_t'(dfh_reg);
                div_den   = lltri_pkg::div_den_t'({1'b0, fu_eff, 12'h000});
            end
            default:
            begin
                div_start = 1'b0;
            end
        endcase
    end

    lltri_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_num),
        .divisor  (div_den),
        .stat     (div_stat),
        .quotient (div_quo)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (in_accept)
                    state_next = (frame_start && epoch_full) ? ST_CLEAR : ST_LOOK;
            ST_CLEAR:
                if (clear_last)
                    state_next = pending_reg ? ST_RD : ST_IDLE;
            ST_RD:   state_next = ST_LOOK;
            ST_LOOK: state_next = fresh_hit ? ST_XD : ST_IDLE;
            ST_XD:   state_next = ST_XDW;
            ST_XDW:
                if (div_stat.done)
                    state_next = ST_YD;
            ST_YD:   state_next = ST_YDW;
            ST_YDW:
                if (div_stat.done)
                    state_next = ST_SQA;
            ST_SQA:  state_next = ST_R2;
            ST_R2:   state_next = ST_R4;
            ST_R4:   state_next = ST_FT;
            ST_FT:   state_next = ST_F;
            ST_F:    state_next = ST_E;
            ST_E:    state_next = ST_N1;
            ST_N1:   state_next = ST_N2;
            ST_N2:   state_next = ST_N3;
            ST_N3:   state_next = ST_SQRT;
            ST_SQRT:
                if (sq_bit_reg == 34'd1)
                    state_next = ST_ZD;
            ST_ZD:   state_next = (den_reg == '0) ? ST_Y1 : ST_ZDW;
            ST_ZDW:
                if (div_stat.done)
                    state_next = ST_Y1;
            ST_Y1:   state_next = ST_YD2;
            ST_YD2:  state_next = ST_YDW2;
            ST_YDW2:
                if (div_stat.done)
                    state_next = ST_DONE;
            ST_DONE:
                if (out_load)
                    state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            epoch_reg     <= lltri_pkg::EPOCH_W'(1);
            clr_cnt_reg   <= '0;
            pending_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR)
            begin
                clr_cnt_reg <= clear_last ? '0 : clr_cnt_reg + 1'b1;
                if (clear_last)
                begin
                    epoch_reg   <= lltri_pkg::EPOCH_W'(1);
                    pending_reg <= 1'b0;
                end
            end
            else if (in_accept && frame_start)
            begin
                if (epoch_full)
                    pending_reg <= 1'b1;
                else
                    epoch_reg <= epoch_reg + 1'b1;
            end
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fu_reg <= 16'd1388;
            fv_reg <= 16'd1388;
            cu_reg <= 12'd970;
            cv_reg <= 12'd553;
            k1_reg <= 16'sd1671;
            k2_reg <= -16'sd2785;
            h_reg  <= 16'd3250;
            b_reg  <= 16'd2921;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_FOCAL_U:  fu_reg <= cfg_data;
                CFG_FOCAL_V:  fv_reg <= cfg_data;
                CFG_CENTER_U: cu_reg <= cfg_data[11:0];
                CFG_CENTER_V: cv_reg <= cfg_data[11:0];
                CFG_K1:       k1_reg <= $signed(cfg_data);
                CFG_K2:       k2_reg <= $signed(cfg_data);
                CFG_HEIGHT:   h_reg  <= cfg_data;
                CFG_BASELINE: b_reg  <= cfg_data;
                default:      fu_reg <= fu_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
                if (in_accept)
                begin
                    col_reg    <= column;
                    row_reg    <= row;
                    hit_ok_reg <= (gray_level > lltri_pkg::THRESHOLD)
                                  && (col_ext_in < lltri_pkg::COLX_W'(lltri_pkg::MAX_COLUMNS));
                end
            ST_XDW:
                if (div_stat.done)
                    xd_reg <= $signed(div_quo[28:0]);
            ST_YDW:
                if (div_stat.done)
                    yd_reg <= $signed(div_quo[28:0]);
            ST_SQA:
            begin
                xsq_reg <= xsq_full[56:0];
                ysq_reg <= ysq_full[56:0];
            end
            ST_R2:
                r2_reg <= (|r2_sum[57:47]) ? 31'h7FFFFFFF : r2_sum[46:16];
            ST_R4:
                r4_reg <= r4_full[61:16];
            ST_FT:
            begin
                t1_reg <= t1_full;
                t2_reg <= t2_full;
            end
            ST_F:
            begin
                if (f_sh > 50'sd1048576)
                    f_reg <= 22'sd1048576;
                else if (f_sh < -50'sd1048576)
                    f_reg <= -22'sd1048576;
                else
                    f_reg <= f_sh[21:0];
            end
            ST_E:
                e_reg <= e_full[34:8];
            ST_N1:
            begin
                fvh_reg <= fv_eff * h_reg;
                fvb_reg <= fv_eff * b_reg;
                eb_reg  <= eb_full;
                he_reg  <= he_full;
                hh_reg  <= h_reg * h_reg;
                bb_reg  <= b_reg * b_reg;
            end
            ST_N2:
            begin
                num_reg    <= $signed({6'b0, fvh_reg, 8'h00}) - 46'(eb_reg);
                den_reg    <= $signed({6'b0, fvb_reg, 8'h00}) + 46'(he_reg);
                sq_x_reg   <= 34'(hh_reg) + 34'(bb_reg);
                sq_res_reg <= '0;
                sq_bit_reg <= 34'h100000000;
            end
            ST_N3:
            begin
                nb_reg  <= $signed({nb_full[58:0], 4'h0});
                duf_reg <= duf_full;
            end
            ST_SQRT:
            begin
                if (sq_x_reg >= sq_sum)
                begin
                    sq_x_reg   <= sq_x_reg - sq_sum;
                    sq_res_reg <= (sq_res_reg >> 1) + sq_bit_reg;
                end
                else
                begin
                    sq_res_reg <= sq_res_reg >> 1;
                end
                sq_bit_reg <= sq_bit_reg >> 2;
            end
            ST_ZD:
                if (den_reg == '0)
                    z_reg <= 24'sh7FFFFF;
            ST_ZDW:
                if (div_stat.done)
                    z_reg <= sat24(z_full);
            ST_Y1:
                dfh_reg <= dfh_full;
            ST_YDW2:
                if (div_stat.done)
                    y_reg <= sat24(64'(div_quo));
            default:
            begin
                col_reg <= col_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            hit_column_reg     <= col_reg;
            hit_row_reg        <= row_reg;
            lateral_offset_reg <= y_reg;
            depth_reg          <= z_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign hit_column     = hit_column_reg;
    assign hit_row        = hit_row_reg;
    assign lateral_offset = lateral_offset_reg;
    assign depth          = depth_reg;

    `LLT_ASSERT_IMP(a_div_done_in_wait, div_stat.done, (state_reg == ST_XDW || state_reg == ST_YDW || state_reg == ST_ZDW || state_reg == ST_YDW2), "divider finished outside a wait state")
    `LLT_ASSERT_IMP(a_div_start_free, div_start, !div_stat.busy, "divider started while busy")
    `LLT_ASSERT_IMP(a_epoch_live, state_reg != ST_CLEAR, epoch_reg != '0, "zero epoch outside the tag sweep")
    `LLT_ASSERT_NXT(a_result_held, (state_reg == ST_DONE) && out_valid_reg && out_stall, state_reg == ST_DONE, "result overwrote a waiting word")

endmodule

`default_nettype wire

// File: tb/sv/lltri_tb_pkg.sv
// register indexes shared by the triangulation testbench modules
package lltri_tb_pkg;

    typedef enum logic [2:0] {
        REG_FOCAL_U,
        REG_FOCAL_V,
        REG_CENTER_U,
        REG_CENTER_V,
        REG_RADIAL_K1,
        REG_RADIAL_K2,
        REG_LASER_HEIGHT,
        REG_CAMERA_BASELINE
    } cfg_reg_t;

endpackage

// File: tb/sv/laser_line_column_triangulation_checker.sv
// checker that predicts and compares the triangulation results of the block
module laser_line_column_triangulation_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic [7:0]         gray_level,
    input  logic [10:0]        column,
    input  logic [10:0]        row,
    input  logic               frame_start,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic [10:0]        hit_column,
    input  logic [10:0]        hit_row,
    input  logic signed [23:0] lateral_offset,
    input  logic signed [23:0] depth,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    output int                 fail_count,
    output int                 pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [10:0]        col;
        logic [10:0]        row;
        logic signed [23:0] lateral;
        logic signed [23:0] depth;
    } hit_t;

    logic [15:0]        focal_u, focal_v, laser_height, camera_baseline;
    logic [11:0]        center_u, center_v;
    logic signed [15:0] radial_k1, radial_k2;
    bit                 col_hit [lltri_pkg::MAX_COLUMNS];
    hit_t               expected_hits [$];

    assign pending = expected_hits.size();

    function automatic longint sat24(longint x);
        if (x > 64'sd8388607)
            return 64'sd8388607;
        if (x < -64'sd8388608)
            return -64'sd8388608;
        return x;
    endfunction

    function automatic longint isqrt(longint unsigned x);
        longint unsigned res;
        longint unsigned bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > x)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (x >= res + bitv)
            begin
                x = x - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return longint'(res);
    endfunction

    function automatic hit_t triangulate(logic [10:0] col, logic [10:0] rw);
        longint fu, fv, h, b, k1, k2, du, dv, xd, yd, r2, r4, f, e, num, den, z, y, hyp;
        hit_t   res;
        fu = (focal_u == 0) ? 1 : longint'(focal_u);
        fv = (focal_v == 0) ? 1 : longint'(focal_v);
        h = longint'(laser_height);
        b = longint'(camera_baseline);
        k1 = longint'(radial_k1);
        k2 = longint'(radial_k2);
        du = longint'(col) - longint'(center_u);
        dv = longint'(rw) - longint'(center_v);
        xd = (du * 65536) / fu;
        yd = (dv * 65536) / fv;
        r2 = (xd * xd + yd * yd) >>> 16;
        if (r2 > 64'sh7FFFFFFF)
            r2 = 64'sh7FFFFFFF;
        r4 = (r2 * r2) >>> 16;
        f = ((longint'(1) << 30) + k1 * r2 + k2 * r4) >>> 14;
        if (f > 64'sd1048576)
            f = 64'sd1048576;
        if (f < -64'sd1048576)
            f = -64'sd1048576;
        e = (-dv * f) >>> 8;
        num = fv * h * 256 - e * b;
        den = fv * b * 256 + h * e;
        if (den == 0)
            z = 64'sd8388607;
        else
            z = sat24(h * 16 - (num * b * 16) / den);
        hyp = isqrt(longint'(h * h + b * b));
        y = sat24((du * f * hyp) / (fu * 4096));
        res.col = col;
        res.row = rw;
        res.lateral = y[23:0];
        res.depth = z[23:0];
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        hit_t got, exp_hit;
        if (!rst_n)
        begin
            focal_u <= 16'd1388;
            focal_v <= 16'd1388;
            center_u <= 12'd970;
            center_v <= 12'd553;
            radial_k1 <= 16'sd1671;
            radial_k2 <= -16'sd2785;
            laser_height <= 16'd3250;
            camera_baseline <= 16'd2921;
            foreach (col_hit[i])
                col_hit[i] = 1'b0;
            expected_hits.delete();
            fail_count <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (lltri_tb_pkg::cfg_reg_t'(cfg_index))
                    lltri_tb_pkg::REG_FOCAL_U:         focal_u <= cfg_data;
                    lltri_tb_pkg::REG_FOCAL_V:         focal_v <= cfg_data;
                    lltri_tb_pkg::REG_CENTER_U:        center_u <= cfg_data[11:0];
                    lltri_tb_pkg::REG_CENTER_V:        center_v <= cfg_data[11:0];
                    lltri_tb_pkg::REG_RADIAL_K1:       radial_k1 <= cfg_data;
                    lltri_tb_pkg::REG_RADIAL_K2:       radial_k2 <= cfg_data;
                    lltri_tb_pkg::REG_LASER_HEIGHT:    laser_height <= cfg_data;
                    lltri_tb_pkg::REG_CAMERA_BASELINE: camera_baseline <= cfg_data;
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
            begin
                if (frame_start)
                    foreach (col_hit[i])
                        col_hit[i] = 1'b0;
                if (gray_level > lltri_pkg::THRESHOLD && !col_hit[column])
                begin
                    col_hit[column] = 1'b1;
                    expected_hits.insert(expected_hits.size(), triangulate(column, row));
                end
            end
            if (out_valid && !out_stall)
            begin
                got = {hit_column, hit_row, lateral_offset, depth};
                if (expected_hits.size() == 0)
                begin
                    $display("%0t: unexpected word col %0d row %0d y %0d z %0d", $time,
                             hit_column, hit_row, lateral_offset, depth);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    exp_hit = expected_hits.pop_front();
                    if (got !== exp_hit)
                    begin
                        $display("%0t: mismatch expected col %0d row %0d y %0d z %0d",
                                 $time, exp_hit.col, exp_hit.row, exp_hit.lateral,
                                 exp_hit.depth);
                        $display("%0t:          actual col %0d row %0d y %0d z %0d",
                                 $time, got.col, got.row, got.lateral, got.depth);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

// File: tb/sv/laser_line_column_triangulation_test.sv
// testbench top for the laser line column triangulation block
module laser_line_column_triangulation_test;
    timeunit 1ns;
    timeprecision 1ps;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [7:0]         gray_level = '0;
    logic [10:0]        column = '0;
    logic [10:0]        row = '0;
    logic               frame_start = 1'b0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [10:0]        hit_column;
    logic [10:0]        hit_row;
    logic signed [23:0] lateral_offset;
    logic signed [23:0] depth;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [2:0]         cfg_index = '0;
    logic [15:0]        cfg_data = '0;
    int                 fail_count;
    int                 pending;
    int                 send_idle_pct = 0;
    int                 recv_idle_pct = 0;

    laser_line_column_triangulation dut (.*);

    laser_line_column_triangulation_checker checker_i (.*);

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(negedge clk)
        out_stall <= rst_n && ($urandom_range(99) < recv_idle_pct);

    task automatic send_pixel(int gray, int col, int rw, bit fs);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        gray_level <= gray[7:0];
        column <= col[10:0];
        row <= rw[10:0];
        frame_start <= fs;
        do
            @(posedge clk);
        while (in_stall);
        @(negedge clk);
    endtask

    task automatic write_reg(lltri_tb_pkg::cfg_reg_t idx, int value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value[15:0];
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic write_all(int fu, int fv, int cu, int cv, int k1, int k2, int h, int b);
        write_reg(lltri_tb_pkg::REG_FOCAL_U, fu);
        write_reg(lltri_tb_pkg::REG_FOCAL_V, fv);
        write_reg(lltri_tb_pkg::REG_CENTER_U, cu);
        write_reg(lltri_tb_pkg::REG_CENTER_V, cv);
        write_reg(lltri_tb_pkg::REG_RADIAL_K1, k1);
        write_reg(lltri_tb_pkg::REG_RADIAL_K2, k2);
        write_reg(lltri_tb_pkg::REG_LASER_HEIGHT, h);
        write_reg(lltri_tb_pkg::REG_CAMERA_BASELINE, b);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        wait (pending == 0);
        repeat (400) @(posedge clk);
        @(negedge clk);
    endtask

    // well-formed frames over a few neighboring columns, with some noise
    task automatic send_frames(int count);
        int sent, ncols, nrows, base_col, base_row, gray;
        sent = 0;
        while (sent < count)
        begin
            if ($urandom_range(9) == 0)
            begin
                send_pixel($urandom_range(255), $urandom_range(2047), $urandom_range(2047),
                           $urandom_range(19) == 0);
                sent++;
            end
            else
            begin
                ncols = $urandom_range(1, 6);
                nrows = $urandom_range(1, 4);
                base_col = $urandom_range(2048 - ncols);
                base_row = $urandom_range(2048 - nrows);
                for (int r = 0; r < nrows; r++)
                    for (int c = 0; c < ncols; c++)
                    begin
                        gray = ($urandom_range(99) < 35) ? $urandom_range(46, 255)
                                                          : $urandom_range(45);
                        send_pixel(gray, base_col + c, base_row + r, r == 0 && c == 0);
                        sent++;
                    end
            end
        end
    endtask

    initial
    begin
        #2000000;
        $display("Some tests failed");
        $finish;
    end

    initial
    begin
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_pixel(100, 5, 5, 1'b0);
        send_pixel(255, 0, 0, 1'b1);
        send_pixel(45, 1, 0, 1'b0);
        send_pixel(46, 1, 2047, 1'b0);
        send_pixel(255, 0, 1, 1'b0);
        send_pixel(200, 2047, 2047, 1'b0);
        send_pixel(128, 970, 553, 1'b0);
        send_pixel(170, 1365, 682, 1'b0);
        send_pixel(0, 2046, 1024, 1'b0);
        send_pixel(255, 0, 3, 1'b1);
        drain();

        // zero focal length and a zero depth denominator
        write_all(0, 1, 0, 100, 0, 0, 1, 1);
        send_pixel(255, 3, 101, 1'b1);
        send_pixel(255, 4, 0, 1'b0);
        drain();

        write_all(1, 1, 0, 0, -32768, -32768, 1, 1);
        send_pixel(255, 0, 0, 1'b1);
        send_pixel(255, 2047, 2047, 1'b0);
        send_pixel(90, 1000, 1500, 1'b0);
        drain();

        write_all(65535, 65535, 4095, 4095, 32767, 32767, 65535, 65535);
        send_pixel(255, 0, 0, 1'b1);
        send_pixel(255, 2047, 2047, 1'b0);
        send_pixel(90, 1000, 1500, 1'b0);
        drain();

        write_all(1388, 1388, 970, 553, 1671, -2785, 3250, 2921);
        send_idle_pct = 28;
        recv_idle_pct = 80;
        send_frames(60);
        drain();

        write_all($urandom_range(500, 3000), $urandom_range(500, 3000), $urandom_range(4095),
                  $urandom_range(4095), $urandom_range(65535), $urandom_range(65535),
                  $urandom_range(1, 65535), $urandom_range(1, 65535));
        send_idle_pct = 80;
        recv_idle_pct = 28;
        send_frames(60);
        drain();

        write_all($urandom_range(1, 65535), $urandom_range(1, 65535), $urandom_range(4095),
                  $urandom_range(4095), $urandom_range(65535), $urandom_range(65535),
                  $urandom_range(1, 65535), $urandom_range(1, 65535));
        send_idle_pct = 0;
        recv_idle_pct = 0;
        // long run of dark frame starts to reach the periodic tag sweep
        for (int i = 0; i < 250; i++)
            send_pixel($urandom_range(45), $urandom_range(2047), $urandom_range(2047), 1'b1);
        send_frames(60);

        in_valid <= 1'b0;
        wait (pending == 0);
        repeat (400) @(posedge clk);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// File: files.f
+incdir+design
design/lltri_pkg.sv
design/lltri_div.sv
design/laser_line_column_triangulation.sv
tb/sv/lltri_tb_pkg.sv
tb/sv/laser_line_column_triangulation_checker.sv
tb/sv/laser_line_column_triangulation_test.sv
